### rtl/ts_pat_single_program_rewriter_unit_defines.svh
`ifndef TS_PAT_SINGLE_PROGRAM_REWRITER_UNIT_DEFINES_SVH
`define TS_PAT_SINGLE_PROGRAM_REWRITER_UNIT_DEFINES_SVH

// Same-cycle implication, gated by reset.
`define TPSR_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tpsr check failed");

// Next-cycle implication, gated by reset.
`define TPSR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tpsr check failed");

`endif

### rtl/tpsr_pkg.sv
`timescale 1ns / 1ps

package tpsr_pkg;

  localparam int PACKET_BYTES_DEF = 188;
  localparam int SECTION_TAIL     = 16;
  localparam int PTR_W            = 9;
  localparam int LAST_W           = 13;
  localparam int SECT_W           = 8;
  localparam int CFG_ADDR_W       = 3;

  localparam logic [7:0]  SYNC_BYTE          = 8'h47;
  localparam logic [31:0] CRC_POLY           = 32'h04c11db7;
  localparam logic [31:0] CRC_INIT           = 32'hffffffff;
  localparam logic [7:0]  NEW_SECTION_LENGTH = 8'(8 + 4 + 4 - 3);
  localparam logic [7:0]  FILL_BYTE          = 8'hff;
  localparam logic [7:0]  LEN_HI_KEEP        = 8'hf0;

  localparam int OFF_LEN_HI = 1;
  localparam int OFF_LEN_LO = 2;
  localparam int OFF_ENTRY  = 8;
  localparam int OFF_CRC    = 12;
  localparam int OFF_FILL   = 16;

  localparam logic [15:0] SERVICE_ID_RST  = 16'd1;
  localparam logic [7:0]  ERROR_LIMIT_RST = 8'd100;
  localparam logic [7:0]  ERROR_SAT       = 8'hff;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  localparam logic [1:0] ST_PASS      = 2'd0;
  localparam logic [1:0] ST_REWRITTEN = 2'd1;
  localparam logic [1:0] ST_BROKEN    = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  localparam logic REG_SERVICE_ID  = 1'b0;
  localparam logic REG_ERROR_LIMIT = 1'b1;

  typedef struct packed {
    logic       opcode;
    logic [7:0] in_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_first;
    logic       out_last;
    logic [1:0] out_status;
    logic       out_stopped;
  } result_t;

  typedef struct packed {
    logic              is_pat;
    logic              broken;
    logic              found;
    logic [SECT_W-1:0] section_start;
    logic [31:0]       entry;
  } scan_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {b, 24'h000000};
    for (int k = 0; k < 8; k++) begin
      c = c[31] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

### rtl/tpsr_ram.sv
`timescale 1ns / 1ps

module tpsr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 188
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/tpsr_pat_scan.sv
`timescale 1ns / 1ps

module tpsr_pat_scan #(
  parameter int PACKET_BYTES = tpsr_pkg::PACKET_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            advance,
  input  logic [$clog2(PACKET_BYTES)-1:0] pos,
  input  logic [7:0]                      data,
  input  logic [15:0]                     service_id,
  output tpsr_pkg::scan_t                 scan
);

  import tpsr_pkg::*;

  localparam int POS_W = $clog2(PACKET_BYTES);
  localparam logic [PTR_W-1:0] S_LIMIT = PTR_W'(PACKET_BYTES - SECTION_TAIL);

  logic              sync_ok, sync_ok_next;
  logic              pid_zero, pid_zero_next;
  logic              hdr_bad, hdr_bad_next;
  logic              adapt, adapt_next;
  logic              pp_armed, pp_armed_next;
  logic [PTR_W-1:0]  pp, pp_next;
  logic              ptr_seen, ptr_seen_next;
  logic              s_ok, s_ok_next;
  logic [POS_W-1:0]  sect, sect_next;
  logic              tid_ok, tid_ok_next;
  logic [3:0]        len_hi, len_hi_next;
  logic              q_on, q_on_next;
  logic [PTR_W-1:0]  q, q_next;
  logic [LAST_W-1:0] last, last_next;
  logic [23:0]       hist, hist_next;
  logic              found, found_next;
  logic [31:0]       entry, entry_next;

  logic [PTR_W-1:0]  pos_x;
  logic [PTR_W-1:0]  sect_x;
  logic [PTR_W-1:0]  s_full;
  logic [31:0]       cand;
  logic              later;
  logic              ptr_hit;

  always_comb begin
    pos_x  = PTR_W'(pos);
    sect_x = PTR_W'(sect);
    s_full = pos_x + PTR_W'(data) + PTR_W'(1);
    cand   = {hist, data};
    later  = (pos != '0);
    ptr_hit = later && (((pos == POS_W'(4)) && !adapt) || (pp_armed && (pos_x == pp)));

    sync_ok_next  = sync_ok;
    pid_zero_next = pid_zero;
    hdr_bad_next  = hdr_bad;
    adapt_next    = adapt;
    pp_armed_next = pp_armed;
    pp_next       = pp;
    ptr_seen_next = ptr_seen;
    s_ok_next     = s_ok;
    sect_next     = sect;
    tid_ok_next   = tid_ok;
    len_hi_next   = len_hi;
    q_on_next     = q_on;
    q_next        = q;
    last_next     = last;
    hist_next     = {hist[15:0], data};
    found_next    = found;
    entry_next    = entry;

    case (pos)
      POS_W'(0): begin
        sync_ok_next  = (data == SYNC_BYTE);
        pid_zero_next = 1'b0;
        hdr_bad_next  = 1'b0;
        adapt_next    = 1'b0;
        pp_armed_next = 1'b0;
        ptr_seen_next = 1'b0;
        s_ok_next     = 1'b0;
        tid_ok_next   = 1'b0;
        q_on_next     = 1'b0;
        found_next    = 1'b0;
        entry_next    = '0;
      end
      POS_W'(1): begin
        hdr_bad_next  = data[7] || !data[6];
        pid_zero_next = (data[4:0] == 5'd0);
      end
      POS_W'(2): begin
        pid_zero_next = pid_zero && (data == 8'd0);
      end
      POS_W'(3): begin
        hdr_bad_next = hdr_bad || !data[4];
        adapt_next   = data[5];
      end
      POS_W'(4): begin
        if (adapt) begin
          pp_armed_next = 1'b1;
          pp_next       = PTR_W'(data) + PTR_W'(5);
        end
      end
      default: begin
      end
    endcase

    if (ptr_hit) begin
      ptr_seen_next = 1'b1;
      s_ok_next     = (s_full < S_LIMIT);
      sect_next     = s_full[POS_W-1:0];
    end

    if (later && s_ok && (pos_x == sect_x)) begin
      tid_ok_next = (data == 8'd0);
    end
    if (later && s_ok && (pos_x == sect_x + PTR_W'(1))) begin
      len_hi_next = data[3:0];
    end
    if (later && s_ok && (pos_x == sect_x + PTR_W'(2))) begin
      last_next = LAST_W'(sect) + LAST_W'({len_hi, data}) - LAST_W'(1);
      q_next    = sect_x + PTR_W'(OFF_ENTRY);
      q_on_next = 1'b1;
    end

    if (later && q_on && (pos_x == q + PTR_W'(3))) begin
      if (!found && (LAST_W'(q) < last) && (cand[31:16] == service_id)) begin
        found_next = 1'b1;
        entry_next = cand;
      end
      q_next = q + PTR_W'(4);
    end
  end

  always_comb begin
    scan.is_pat        = sync_ok_next && pid_zero_next;
    scan.broken        = hdr_bad_next || !ptr_seen_next || !s_ok_next || !tid_ok_next;
    scan.found         = found_next;
    scan.section_start = SECT_W'(sect_next);
    scan.entry         = entry_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_ok  <= 1'b0;
      pid_zero <= 1'b0;
      hdr_bad  <= 1'b0;
      adapt    <= 1'b0;
      pp_armed <= 1'b0;
      ptr_seen <= 1'b0;
      s_ok     <= 1'b0;
      tid_ok   <= 1'b0;
      q_on     <= 1'b0;
      found    <= 1'b0;
    end else if (advance) begin
      sync_ok  <= sync_ok_next;
      pid_zero <= pid_zero_next;
      hdr_bad  <= hdr_bad_next;
      adapt    <= adapt_next;
      pp_armed <= pp_armed_next;
      ptr_seen <= ptr_seen_next;
      s_ok     <= s_ok_next;
      tid_ok   <= tid_ok_next;
      q_on     <= q_on_next;
      found    <= found_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pp     <= pp_next;
      sect   <= sect_next;
      len_hi <= len_hi_next;
      q      <= q_next;
      last   <= last_next;
      hist   <= hist_next;
      entry  <= entry_next;
    end
  end

endmodule

### rtl/ts_pat_single_program_rewriter_unit.sv
`timescale 1ns / 1ps

// Channel   Signals                               Transfer when
// item      item_valid, item_stall, item          item_valid && !item_stall
// result    result_valid, result_stall, result    result_valid && !result_stall
// config    psel, penable, pwrite, paddr, pwdata  psel && penable && pwrite && pready
//
// One byte per clock unless a result stalls; store reads every item, writes load items.
// A byte is registered in the middle stage, then its result in the result register.
// Output runs one packet behind: the held packet goes out while the next one loads.
// Reset is synchronous; service_id returns to 1, error_limit to 100, store is undefined.
// A stalled result holds the result register; item_stall rises only when a byte
// waiting in the middle stage has nowhere to go.

module ts_pat_single_program_rewriter_unit #(
  parameter int PACKET_BYTES = tpsr_pkg::PACKET_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  output logic                            item_stall,
  input  tpsr_pkg::item_t                 item,
  output logic                            result_valid,
  input  logic                            result_stall,
  output tpsr_pkg::result_t               result,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tpsr_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  import tpsr_pkg::*;

  localparam int POS_W = $clog2(PACKET_BYTES);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(PACKET_BYTES - 1);

  logic [15:0]      service_id;
  logic [7:0]       error_limit;
  logic             cfg_write;
  logic             reg_idx;

  logic             accept;
  logic             enter;
  logic [POS_W-1:0] pos, pos_next;
  logic             held, held_next;

  logic             s1_valid;
  logic             s1_op;
  logic [7:0]       s1_byte;
  logic [POS_W-1:0] s1_pos;
  logic             s1_emit;
  logic             s1_fire;
  logic             out_free;
  logic             emit_fire;
  logic             complete;

  logic [7:0]       ram_q;
  logic [7:0]       scan_byte;
  scan_t            scan;

  logic [1:0]        held_status;
  logic [SECT_W-1:0] held_start;
  logic [31:0]       held_entry;
  logic [31:0]       crc, crc_next;
  logic [7:0]        error_count, error_count_next;
  logic              stopped, stopped_next;
  logic              checked;
  logic [1:0]        chk_status;

  logic [POS_W-1:0] off;
  logic             rewrite;
  logic [7:0]       out_v;
  result_t          result_next;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_idx   = paddr[CFG_ADDR_W-1];

  always_comb begin
    unique case (reg_idx)
      REG_SERVICE_ID:  prdata = {16'd0, service_id};
      REG_ERROR_LIMIT: prdata = {24'd0, error_limit};
      default:         prdata = '0;
    endcase
  end

  assign out_free   = !result_valid || !result_stall;
  assign s1_fire    = s1_valid && (!s1_emit || out_free);
  assign emit_fire  = s1_fire && s1_emit;
  assign item_stall = s1_valid && !s1_fire;
  assign accept     = item_valid && !item_stall;
  assign enter      = accept && !((item.opcode == OP_DRAIN) && !held);
  assign complete   = s1_fire && (s1_op == OP_LOAD) && (s1_pos == POS_LAST);

  always_comb begin
    pos_next  = pos;
    held_next = held;
    if (accept) begin
      if (item.opcode == OP_DRAIN) begin
        if (held) begin
          if (pos == POS_LAST) begin
            pos_next  = '0;
            held_next = 1'b0;
          end else begin
            pos_next = pos + POS_W'(1);
          end
        end
      end else begin
        if (pos == POS_LAST) begin
          pos_next  = '0;
          held_next = 1'b1;
        end else begin
          pos_next = pos + POS_W'(1);
        end
      end
    end
  end

  tpsr_ram #(
    .WIDTH (8),
    .DEPTH (PACKET_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (accept && (item.opcode == OP_LOAD)),
    .waddr (pos),
    .wdata (item.in_byte),
    .re    (accept),
    .raddr (pos),
    .rdata (ram_q)
  );

  assign scan_byte = (s1_op == OP_DRAIN) ? ram_q : s1_byte;

  tpsr_pat_scan #(
    .PACKET_BYTES (PACKET_BYTES)
  ) u_scan (
    .clk        (clk),
    .rst        (rst),
    .advance    (s1_fire),
    .pos        (s1_pos),
    .data       (scan_byte),
    .service_id (service_id),
    .scan       (scan)
  );

  always_comb begin
    off      = s1_pos - POS_W'(held_start);
    rewrite  = (held_status == ST_REWRITTEN) && (s1_pos >= POS_W'(held_start));
    out_v    = ram_q;
    crc_next = crc;
    if (rewrite) begin
      if (off == POS_W'(OFF_LEN_HI)) begin
        out_v = ram_q & LEN_HI_KEEP;
      end else if (off == POS_W'(OFF_LEN_LO)) begin
        out_v = NEW_SECTION_LENGTH;
      end else if ((off >= POS_W'(OFF_ENTRY)) && (off < POS_W'(OFF_CRC))) begin
        case (off[1:0])
          2'd0:    out_v = held_entry[31:24];
          2'd1:    out_v = held_entry[23:16];
          2'd2:    out_v = held_entry[15:8];
          default: out_v = held_entry[7:0];
        endcase
      end else if ((off >= POS_W'(OFF_CRC)) && (off < POS_W'(OFF_FILL))) begin
        case (off[1:0])
          2'd0:    out_v = crc[31:24];
          2'd1:    out_v = crc[23:16];
          2'd2:    out_v = crc[15:8];
          default: out_v = crc[7:0];
        endcase
      end else if (off >= POS_W'(OFF_FILL)) begin
        out_v = FILL_BYTE;
      end
      if (off < POS_W'(OFF_CRC)) begin
        crc_next = crc_byte(crc, out_v);
      end
    end
    result_next.out_byte    = out_v;
    result_next.out_first   = (s1_pos == '0);
    result_next.out_last    = (s1_pos == POS_LAST);
    result_next.out_status  = held_status;
    result_next.out_stopped = stopped;
  end

  always_comb begin
    checked = !stopped && scan.is_pat;
    if (!checked) begin
      chk_status = ST_PASS;
    end else if (scan.broken) begin
      chk_status = ST_BROKEN;
    end else if (scan.found) begin
      chk_status = ST_REWRITTEN;
    end else begin
      chk_status = ST_NOT_FOUND;
    end
    error_count_next = error_count;
    if (checked && (chk_status != ST_REWRITTEN) && (error_count != ERROR_SAT)) begin
      error_count_next = error_count + 8'd1;
    end
    stopped_next = stopped || (checked && (error_count_next > error_limit));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      service_id  <= SERVICE_ID_RST;
      error_limit <= ERROR_LIMIT_RST;
    end else if (cfg_write) begin
      if (reg_idx == REG_SERVICE_ID) begin
        service_id <= pwdata[15:0];
      end else begin
        error_limit <= pwdata[7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      held     <= 1'b0;
      s1_valid <= 1'b0;
    end else begin
      pos  <= pos_next;
      held <= held_next;
      if (!s1_valid || s1_fire) begin
        s1_valid <= enter;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (enter) begin
      s1_op   <= item.opcode;
      s1_byte <= item.in_byte;
      s1_pos  <= pos;
      s1_emit <= held;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_status <= ST_PASS;
      held_start  <= '0;
      held_entry  <= '0;
      crc         <= CRC_INIT;
      error_count <= '0;
      stopped     <= 1'b0;
    end else begin
      if (emit_fire) begin
        crc <= crc_next;
      end
      if (complete) begin
        held_status <= chk_status;
        held_start  <= (chk_status == ST_REWRITTEN) ? scan.section_start : '0;
        held_entry  <= (chk_status == ST_REWRITTEN) ? scan.entry : '0;
        crc         <= CRC_INIT;
        error_count <= error_count_next;
        stopped     <= stopped_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= emit_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      result <= result_next;
    end
  end

endmodule

### rtl/tpsr_checker.sv
`timescale 1ns / 1ps
`include "ts_pat_single_program_rewriter_unit_defines.svh"

module tpsr_checker (
  input logic              clk,
  input logic              rst,
  input logic              item_stall,
  input logic              result_valid,
  input logic              result_stall,
  input tpsr_pkg::result_t result
);

  `TPSR_ASSERT_NEXT(a_result_hold, clk, rst, result_valid && result_stall,
                    result_valid && $stable(result))
  `TPSR_ASSERT_NOW(a_stall_cause, clk, rst, item_stall, result_valid && result_stall)
  `TPSR_ASSERT_NEXT(a_stopped_sticky, clk, rst, result_valid && result.out_stopped,
                    !result_valid || result.out_stopped)
  `TPSR_ASSERT_NEXT(a_first_after_last, clk, rst,
                    result_valid && !result_stall && result.out_last,
                    !result_valid || result.out_first)
  `TPSR_ASSERT_NEXT(a_no_first_mid, clk, rst,
                    result_valid && !result_stall && !result.out_last,
                    !result_valid || !result.out_first)

endmodule

bind ts_pat_single_program_rewriter_unit tpsr_checker u_tpsr_checker (.*);
